@@ sv/eipl_pkg.sv @@
`timescale 1ns / 1ps

package eipl_pkg;

  // result kinds
  localparam logic [2:0] KIND_SHORT     = 3'd0;
  localparam logic [2:0] KIND_NON_IP    = 3'd1;
  localparam logic [2:0] KIND_TCP       = 3'd2;
  localparam logic [2:0] KIND_UDP       = 3'd3;
  localparam logic [2:0] KIND_ICMP      = 3'd4;
  localparam logic [2:0] KIND_OTHER_IP  = 3'd5;
  localparam logic [2:0] KIND_TRUNCATED = 3'd6;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
  localparam int          TCP_ACK_BIT    = 4;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [3:0]  tcp_words;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] udp_len;
  } fields_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [15:0] window_size;
    logic [15:0] payload_length;
  } result_t;

endpackage

@@ sv/eipl_if.sv @@
`timescale 1ns / 1ps

interface eipl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eipl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [7:0]  tcp_flag_bits;
  logic [31:0] sequence_number;
  logic [31:0] ack_number;
  logic [15:0] window_size;
  logic [15:0] payload_length;

  modport source (
    output valid, output kind, output ip_protocol, output source_address,
    output destination_address, output source_port, output destination_port,
    output tcp_flag_bits, output sequence_number, output ack_number,
    output window_size, output payload_length, input ready
  );
  modport sink (
    input valid, input kind, input ip_protocol, input source_address,
    input destination_address, input source_port, input destination_port,
    input tcp_flag_bits, input sequence_number, input ack_number,
    input window_size, input payload_length, output ready
  );
endinterface

@@ sv/eipl_capture.sv @@
`timescale 1ns / 1ps

module eipl_capture (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic [15:0]       byte_pos,
  output eipl_pkg::fields_t fields_nxt
);

  logic [15:0]       count_r;
  logic [15:0]       count_nxt;
  eipl_pkg::fields_t fields_r;
  logic [6:0]        l4_base;
  logic [15:0]       l4_off;
  logic              in_l4;
  logic [3:0]        rel;

  assign byte_pos = count_r;

  // transport header starts at 14 + 4 * ihl
  assign l4_base = 7'd14 + {1'b0, fields_r.ihl, 2'b00};
  assign l4_off  = count_r - {9'd0, l4_base};
  assign in_l4   = (count_r > 16'd14) && (fields_r.ihl >= eipl_pkg::MIN_HDR_WORDS) &&
                   (count_r >= {9'd0, l4_base}) && (l4_off < 16'd16);
  assign rel     = l4_off[3:0];

  always_comb begin
    fields_nxt = fields_r;
    if (count_r == 16'd12 || count_r == 16'd13) begin
      fields_nxt.eth_type = {fields_r.eth_type[7:0], data_byte};
    end
    if (count_r == 16'd14) begin
      fields_nxt.ihl = data_byte[3:0];
    end
    if (count_r == 16'd16 || count_r == 16'd17) begin
      fields_nxt.total_len = {fields_r.total_len[7:0], data_byte};
    end
    if (count_r == 16'd23) begin
      fields_nxt.proto = data_byte;
    end
    if (count_r >= 16'd26 && count_r <= 16'd29) begin
      fields_nxt.src_addr = {fields_r.src_addr[23:0], data_byte};
    end
    if (count_r >= 16'd30 && count_r <= 16'd33) begin
      fields_nxt.dst_addr = {fields_r.dst_addr[23:0], data_byte};
    end
    if (in_l4) begin
      case (rel)
        4'd0, 4'd1: begin
          fields_nxt.src_port = {fields_r.src_port[7:0], data_byte};
        end
        4'd2, 4'd3: begin
          fields_nxt.dst_port = {fields_r.dst_port[7:0], data_byte};
        end
        4'd4, 4'd5, 4'd6, 4'd7: begin
          fields_nxt.seq = {fields_r.seq[23:0], data_byte};
        end
        4'd8, 4'd9, 4'd10, 4'd11: begin
          fields_nxt.ack = {fields_r.ack[23:0], data_byte};
        end
        4'd12: begin
          fields_nxt.tcp_words = data_byte[7:4];
        end
        4'd13: begin
          fields_nxt.flags = data_byte;
        end
        default: begin
          fields_nxt.window = {fields_r.window[7:0], data_byte};
        end
      endcase
      // udp length shares the tcp sequence bytes
      if (rel == 4'd4 || rel == 4'd5) begin
        fields_nxt.udp_len = {fields_r.udp_len[7:0], data_byte};
      end
    end
  end

  always_comb begin
    if (last_byte) begin
      count_nxt = 16'd0;
    end else if (count_r == eipl_pkg::COUNT_MAX) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 16'd0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // every field is fully rewritten before it can reach a result
  always_ff @(posedge clk) begin
    if (accept) begin
      fields_r <= fields_nxt;
    end
  end

  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> count_r == 16'd0)
    else $error("byte count not cleared after frame end");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last_byte && count_r != eipl_pkg::COUNT_MAX |=>
      count_r == $past(count_r) + 16'd1)
    else $error("byte count did not advance");

endmodule

@@ sv/eipl_classify.sv @@
`timescale 1ns / 1ps

module eipl_classify (
  input  logic [15:0]       byte_pos,
  input  eipl_pkg::fields_t fields,
  output eipl_pkg::result_t result
);

  logic [5:0]  ihl_bytes;
  logic [5:0]  tcp_bytes;
  logic [15:0] tcp_min_pos;
  logic [15:0] udp_min_pos;
  logic [6:0]  hdr_sum;
  logic [16:0] tcp_diff;

  assign ihl_bytes   = {fields.ihl, 2'b00};
  assign tcp_bytes   = {fields.tcp_words, 2'b00};
  // last position index must reach 14 + 4 * ihl + header size - 1
  assign tcp_min_pos = 16'd33 + {10'd0, ihl_bytes};
  assign udp_min_pos = 16'd21 + {10'd0, ihl_bytes};
  assign hdr_sum     = {1'b0, ihl_bytes} + {1'b0, tcp_bytes};
  assign tcp_diff    = {1'b0, fields.total_len} - {10'd0, hdr_sum};

  always_comb begin
    result = '0;
    if (byte_pos < 16'd13) begin
      result.kind = eipl_pkg::KIND_SHORT;
    end else if (fields.eth_type != eipl_pkg::ETHERTYPE_IPV4) begin
      result.kind = eipl_pkg::KIND_NON_IP;
    end else if (byte_pos < 16'd33) begin
      result.kind = eipl_pkg::KIND_SHORT;
    end else if (fields.ihl < eipl_pkg::MIN_HDR_WORDS) begin
      result.kind        = eipl_pkg::KIND_SHORT;
      result.ip_protocol = fields.proto;
    end else begin
      result.ip_protocol         = fields.proto;
      result.source_address      = fields.src_addr;
      result.destination_address = fields.dst_addr;
      if (fields.proto == eipl_pkg::PROTO_TCP) begin
        if (byte_pos < tcp_min_pos || fields.tcp_words < eipl_pkg::MIN_HDR_WORDS) begin
          result.kind = eipl_pkg::KIND_TRUNCATED;
        end else begin
          result.kind             = eipl_pkg::KIND_TCP;
          result.source_port      = fields.src_port;
          result.destination_port = fields.dst_port;
          result.tcp_flag_bits    = fields.flags;
          result.sequence_number  = fields.seq;
          result.window_size      = fields.window;
          result.ack_number       = fields.flags[eipl_pkg::TCP_ACK_BIT] ? fields.ack : 32'd0;
          result.payload_length   = tcp_diff[16] ? 16'd0 : tcp_diff[15:0];
        end
      end else if (fields.proto == eipl_pkg::PROTO_UDP) begin
        if (byte_pos < udp_min_pos) begin
          result.kind = eipl_pkg::KIND_TRUNCATED;
        end else begin
          result.kind             = eipl_pkg::KIND_UDP;
          result.source_port      = fields.src_port;
          result.destination_port = fields.dst_port;
          result.payload_length   = (fields.udp_len > eipl_pkg::UDP_HDR_BYTES) ?
                                    fields.udp_len - eipl_pkg::UDP_HDR_BYTES : 16'd0;
        end
      end else if (fields.proto == eipl_pkg::PROTO_ICMP) begin
        result.kind = eipl_pkg::KIND_ICMP;
      end else begin
        result.kind = eipl_pkg::KIND_OTHER_IP;
      end
    end
  end

endmodule

@@ sv/eth_ipv4_l4_header_parser_unit.sv @@
`timescale 1ns / 1ps

// Parses an Ethernet/IPv4/TCP-UDP frame delivered one byte per request, first
// byte at the destination MAC, last byte flagged by last_byte. One byte is taken
// every clock unless stalled; the per-byte field capture and the end-of-frame
// classification run in one pass from the header field registers into the
// output register, so the result for a frame appears in the cycle after its
// last byte is accepted. Input stalls only while a result sits in the output
// register and the sink is not ready. Non-last bytes produce no result.

module eth_ipv4_l4_header_parser_unit (
  input logic         clk,
  input logic         rst_n,
  eipl_in_if.sink     in_chan,
  eipl_out_if.source  out_chan
);

  logic              in_acc;
  logic [15:0]       byte_pos;
  eipl_pkg::fields_t fields_nxt;
  eipl_pkg::result_t result;
  eipl_pkg::result_t res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  eipl_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .data_byte  (in_chan.data_byte),
    .last_byte  (in_chan.last_byte),
    .byte_pos   (byte_pos),
    .fields_nxt (fields_nxt)
  );

  eipl_classify u_classify (
    .byte_pos (byte_pos),
    .fields   (fields_nxt),
    .result   (result)
  );

  always_comb begin
    if (in_acc && in_chan.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.last_byte) begin
      res_r <= result;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.kind                = res_r.kind;
  assign out_chan.ip_protocol         = res_r.ip_protocol;
  assign out_chan.source_address      = res_r.source_address;
  assign out_chan.destination_address = res_r.destination_address;
  assign out_chan.source_port         = res_r.source_port;
  assign out_chan.destination_port    = res_r.destination_port;
  assign out_chan.tcp_flag_bits       = res_r.tcp_flag_bits;
  assign out_chan.sequence_number     = res_r.sequence_number;
  assign out_chan.ack_number          = res_r.ack_number;
  assign out_chan.window_size         = res_r.window_size;
  assign out_chan.payload_length      = res_r.payload_length;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty output register");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc || !in_chan.last_byte) && (out_chan.ready || !out_valid_r) |=> !out_valid_r)
    else $error("result raised without a frame end");

  a_ack_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.tcp_flag_bits[eipl_pkg::TCP_ACK_BIT] |->
      res_r.ack_number == 32'd0)
    else $error("ack number shown without ack flag");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int ETH_HDR_BYTES = 14;
  localparam int IP_MIN_FRAME  = 34;
  localparam int TCP_MIN_HDR   = 20;
  localparam int FILL_RANDOM   = 0;
  localparam int FILL_ZERO     = 1;
  localparam int FILL_ONES     = 2;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] phase;
  } wire_byte_t;

  logic clk;
  logic rst_n;

  eipl_in_if  in_chan();
  eipl_out_if out_chan();

  eth_ipv4_l4_header_parser_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  // idle and stall odds per phase: none, sender only, receiver only, both
  int send_idle_pct [0:3] = '{0, 48, 0, 30};
  int recv_stall_pct [0:3] = '{0, 0, 48, 30};

  wire_byte_t          wire_bytes [$];
  eipl_pkg::result_t   frame_reports_due [$];
  logic [7:0]          frame_buf [0:65663];

  // shadow of the parser's header registers
  eipl_pkg::fields_t   hdr;
  int unsigned         rx_pos;

  wire_byte_t          next_byte;
  wire_byte_t          head_byte;
  logic [1:0]          cur_phase;
  logic                byte_taken;
  eipl_pkg::result_t   seen;

  int fail_count;
  int bytes_in;
  int frames_checked;
  int random_bytes;
  int random_frames;
  int kind_seen [0:7];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("timeout: %0d frame reports still due, %0d bytes unsent",
             frame_reports_due.size(), wire_bytes.size());
    $display("testbench: errors");
    $finish;
  end

  function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
    int unsigned       pos;
    int unsigned       base;
    int unsigned       rel;
    int unsigned       frame_len;
    int unsigned       ip_hdr_bytes;
    int                net_payload;
    eipl_pkg::result_t r;
    pos = rx_pos;
    if (pos == 12 || pos == 13) hdr.eth_type = {hdr.eth_type[7:0], b};
    if (pos == 14) hdr.ihl = b[3:0];
    if (pos == 16 || pos == 17) hdr.total_len = {hdr.total_len[7:0], b};
    if (pos == 23) hdr.proto = b;
    if (pos >= 26 && pos <= 29) hdr.src_addr = {hdr.src_addr[23:0], b};
    if (pos >= 30 && pos <= 33) hdr.dst_addr = {hdr.dst_addr[23:0], b};
    // transport fields sit right after the ip header, wherever ihl puts it
    if (pos > 14 && hdr.ihl >= eipl_pkg::MIN_HDR_WORDS) begin
      base = ETH_HDR_BYTES + 4 * hdr.ihl;
      if (pos >= base && pos < base + 16) begin
        rel = pos - base;
        if (rel <= 1) hdr.src_port = {hdr.src_port[7:0], b};
        else if (rel <= 3) hdr.dst_port = {hdr.dst_port[7:0], b};
        else if (rel <= 7) hdr.seq = {hdr.seq[23:0], b};
        else if (rel <= 11) hdr.ack = {hdr.ack[23:0], b};
        else if (rel == 12) hdr.tcp_words = b[7:4];
        else if (rel == 13) hdr.flags = b;
        else hdr.window = {hdr.window[7:0], b};
        if (rel == 4 || rel == 5) hdr.udp_len = {hdr.udp_len[7:0], b};
      end
    end
    if (!last) begin
      if (rx_pos < eipl_pkg::COUNT_MAX) rx_pos++;
      return;
    end

    frame_len = pos + 1;
    r = '0;
    if (frame_len < ETH_HDR_BYTES) begin
      r.kind = eipl_pkg::KIND_SHORT;
    end else if (hdr.eth_type != eipl_pkg::ETHERTYPE_IPV4) begin
      r.kind = eipl_pkg::KIND_NON_IP;
    end else if (frame_len < IP_MIN_FRAME) begin
      r.kind = eipl_pkg::KIND_SHORT;
    end else if (hdr.ihl < eipl_pkg::MIN_HDR_WORDS) begin
      r.kind = eipl_pkg::KIND_SHORT;
      r.ip_protocol = hdr.proto;
    end else begin
      ip_hdr_bytes = 4 * hdr.ihl;
      r.ip_protocol = hdr.proto;
      r.source_address = hdr.src_addr;
      r.destination_address = hdr.dst_addr;
      if (hdr.proto == eipl_pkg::PROTO_TCP) begin
        if (frame_len < ETH_HDR_BYTES + ip_hdr_bytes + TCP_MIN_HDR ||
            hdr.tcp_words < eipl_pkg::MIN_HDR_WORDS) begin
          r.kind = eipl_pkg::KIND_TRUNCATED;
        end else begin
          net_payload = hdr.total_len;
          net_payload = net_payload - ip_hdr_bytes - 4 * hdr.tcp_words;
          r.kind = eipl_pkg::KIND_TCP;
          r.source_port = hdr.src_port;
          r.destination_port = hdr.dst_port;
          r.tcp_flag_bits = hdr.flags;
          r.sequence_number = hdr.seq;
          r.window_size = hdr.window;
          r.ack_number = hdr.flags[eipl_pkg::TCP_ACK_BIT] ? hdr.ack : 32'd0;
          r.payload_length = (net_payload > 0) ? net_payload[15:0] : 16'd0;
        end
      end else if (hdr.proto == eipl_pkg::PROTO_UDP) begin
        if (frame_len < ETH_HDR_BYTES + ip_hdr_bytes + eipl_pkg::UDP_HDR_BYTES) begin
          r.kind = eipl_pkg::KIND_TRUNCATED;
        end else begin
          r.kind = eipl_pkg::KIND_UDP;
          r.source_port = hdr.src_port;
          r.destination_port = hdr.dst_port;
          r.payload_length = (hdr.udp_len > eipl_pkg::UDP_HDR_BYTES) ?
                             hdr.udp_len - eipl_pkg::UDP_HDR_BYTES : 16'd0;
        end
      end else if (hdr.proto == eipl_pkg::PROTO_ICMP) begin
        r.kind = eipl_pkg::KIND_ICMP;
      end else begin
        r.kind = eipl_pkg::KIND_OTHER_IP;
      end
    end
    frame_reports_due.push_back(r);
    hdr = '0;
    rx_pos = 0;
  endfunction

  // builds one frame in frame_buf and queues its first len bytes
  task automatic make_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                            input logic [7:0] proto, input logic [15:0] tot_len,
                            input logic [31:0] l4_word, input logic [7:0] doff,
                            input logic [7:0] flg, input int len, input int fill,
                            input logic [1:0] phase);
    int         l4;
    int         hdr_words;
    wire_byte_t item;
    for (int i = 0; i < len || i < 100; i++) begin
      if (fill == FILL_ZERO) frame_buf[i] = 8'h00;
      else if (fill == FILL_ONES) frame_buf[i] = 8'hFF;
      else frame_buf[i] = 8'($urandom_range(255, 0));
    end
    hdr_words = int'(ver_ihl[3:0]);
    if (hdr_words < eipl_pkg::MIN_HDR_WORDS) hdr_words = eipl_pkg::MIN_HDR_WORDS;
    l4 = ETH_HDR_BYTES + 4 * hdr_words;
    frame_buf[12] = etype[15:8];
    frame_buf[13] = etype[7:0];
    frame_buf[14] = ver_ihl;
    frame_buf[16] = tot_len[15:8];
    frame_buf[17] = tot_len[7:0];
    frame_buf[23] = proto;
    for (int k = 0; k < 4; k++) frame_buf[l4 + 4 + k] = l4_word[31 - 8 * k -: 8];
    frame_buf[l4 + 12] = doff;
    frame_buf[l4 + 13] = flg;
    for (int i = 0; i < len; i++) begin
      item.data = frame_buf[i];
      item.last = (i == len - 1);
      item.phase = phase;
      wire_bytes.push_back(item);
    end
  endtask

  task automatic make_random_frame(input logic [1:0] phase);
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [15:0] tot_len;
    logic [31:0] l4_word;
    logic [7:0]  doff;
    int          ihl;
    int          hdr_end;
    int          len;
    int          pick;
    etype = ($urandom_range(9, 0) == 0) ? 16'($urandom) : eipl_pkg::ETHERTYPE_IPV4;
    pick = $urandom_range(99, 0);
    if (pick < 60) ihl = 5;
    else if (pick < 90) ihl = $urandom_range(15, 6);
    else ihl = $urandom_range(4, 0);
    ver_ihl = {4'($urandom_range(15, 0)), 4'(ihl)};
    if (ihl < 5) ihl = 5;
    pick = $urandom_range(99, 0);
    if (pick < 40) proto = eipl_pkg::PROTO_TCP;
    else if (pick < 75) proto = eipl_pkg::PROTO_UDP;
    else if (pick < 85) proto = eipl_pkg::PROTO_ICMP;
    else proto = 8'($urandom_range(255, 0));
    hdr_end = ETH_HDR_BYTES + 4 * ihl;
    if (proto == eipl_pkg::PROTO_TCP) hdr_end += TCP_MIN_HDR;
    else if (proto == eipl_pkg::PROTO_UDP) hdr_end += eipl_pkg::UDP_HDR_BYTES;
    doff = {4'(($urandom_range(99, 0) < 85) ? $urandom_range(15, 5) : $urandom_range(4, 0)),
            4'($urandom_range(15, 0))};
    l4_word = $urandom;
    // udp length lands in the upper half of the word at transport offset 4
    if (proto == eipl_pkg::PROTO_UDP && $urandom_range(1, 0) == 1)
      l4_word[31:16] = 16'($urandom_range(40, 0));
    len = hdr_end + $urandom_range(12, 0);
    pick = $urandom_range(99, 0);
    if (pick < 15) len = $urandom_range(hdr_end - 1, 1);
    else if (pick < 20) len = $urandom_range(20, 1);
    tot_len = ($urandom_range(1, 0) == 1) ? 16'(len - ETH_HDR_BYTES) : 16'($urandom);
    make_frame(etype, ver_ihl, proto, tot_len, l4_word, doff, 8'($urandom), len,
               FILL_RANDOM, phase);
    random_bytes += len;
    random_frames++;
  endtask

  task automatic note_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("mismatch in frame %0d, %s: expected %h, got %h",
                 frames_checked, name, want, got);
    end
  endtask

  task automatic check_frame_report(input eipl_pkg::result_t got);
    eipl_pkg::result_t want;
    if (frame_reports_due.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("unexpected frame report: kind %0d", got.kind);
      return;
    end
    want = frame_reports_due.pop_front();
    note_field("kind", 32'(want.kind), 32'(got.kind));
    note_field("ip_protocol", 32'(want.ip_protocol), 32'(got.ip_protocol));
    note_field("source_address", want.source_address, got.source_address);
    note_field("destination_address", want.destination_address, got.destination_address);
    note_field("source_port", 32'(want.source_port), 32'(got.source_port));
    note_field("destination_port", 32'(want.destination_port), 32'(got.destination_port));
    note_field("tcp_flag_bits", 32'(want.tcp_flag_bits), 32'(got.tcp_flag_bits));
    note_field("sequence_number", want.sequence_number, got.sequence_number);
    note_field("ack_number", want.ack_number, got.ack_number);
    note_field("window_size", 32'(want.window_size), 32'(got.window_size));
    note_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
    kind_seen[want.kind]++;
    frames_checked++;
  endtask

  // byte driver: holds a request until it is taken, idles per phase
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || byte_taken) begin
      if (wire_bytes.size() > 0) begin
        head_byte = wire_bytes[0];
        if ($urandom_range(99, 0) >= send_idle_pct[head_byte.phase]) begin
          next_byte = wire_bytes.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.data_byte <= next_byte.data;
          in_chan.last_byte <= next_byte.last;
          cur_phase <= next_byte.phase;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    out_chan.ready <= ($urandom_range(99, 0) >= recv_stall_pct[cur_phase]);
  end

  // request and report monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        parse_frame_byte(in_chan.data_byte, in_chan.last_byte);
        bytes_in++;
      end
      if (out_chan.valid && out_chan.ready) begin
        seen = {out_chan.kind, out_chan.ip_protocol, out_chan.source_address,
                out_chan.destination_address, out_chan.source_port,
                out_chan.destination_port, out_chan.tcp_flag_bits,
                out_chan.sequence_number, out_chan.ack_number,
                out_chan.window_size, out_chan.payload_length};
        check_frame_report(seen);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = 8'h00;
    in_chan.last_byte = 1'b0;
    out_chan.ready = 1'b0;
    cur_phase = 2'd0;
    byte_taken = 1'b0;
    hdr = '0;
    rx_pos = 0;
    fail_count = 0;
    bytes_in = 0;
    frames_checked = 0;
    random_bytes = 0;
    random_frames = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;

    // runt frames, non-ip, ip cut short, bad ihl
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'd40, 32'h0, 8'h50,
               8'h10, 1, FILL_ONES, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'd40, 32'h0, 8'h50,
               8'h10, 13, FILL_RANDOM, 2'd0);
    make_frame(16'h86DD, 8'h45, eipl_pkg::PROTO_TCP, 16'd40, 32'h0, 8'h50, 8'h10, 14,
               FILL_RANDOM, 2'd0);
    make_frame(16'hFFFF, 8'hFF, eipl_pkg::PROTO_UDP, 16'hFFFF, 32'h0, 8'h50, 8'h10, 60,
               FILL_ONES, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'd40, 32'h0, 8'h50,
               8'h10, 33, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h44, eipl_pkg::PROTO_TCP, 16'd40, 32'h0, 8'h50,
               8'h10, 60, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h40, 8'h00, 16'h0, 32'h0, 8'h00, 8'h00, 34,
               FILL_ZERO, 2'd0);
    // tcp: minimal, ack clear, short by one byte, bad data offset, max options
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'd40, 32'hFFFFFFFF,
               8'h50, 8'hFF, 54, FILL_ONES, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'hFFFF, 32'hFFFFFFFF,
               8'h5F, 8'hEF, 60, FILL_ONES, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'd40, 32'h0, 8'h50,
               8'h10, 53, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'd60, 32'h0, 8'h4F,
               8'h10, 60, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h4F, eipl_pkg::PROTO_TCP, 16'd20, 32'h0, 8'hF0,
               8'h12, 134, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_TCP, 16'h0, 32'h0, 8'h50,
               8'h00, 54, FILL_ZERO, 2'd0);
    // udp: length at, below and far above the header size, one byte short
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_UDP, 16'd28, 32'h00080000,
               8'h00, 8'h00, 42, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_UDP, 16'd28, 32'h0, 8'h00,
               8'h00, 42, FILL_ZERO, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_UDP, 16'hFFFF, 32'hFFFFFFFF,
               8'hFF, 8'hFF, 50, FILL_ONES, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_UDP, 16'd28, 32'h00100000,
               8'h00, 8'h00, 41, FILL_RANDOM, 2'd0);
    // icmp and other protocols
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, eipl_pkg::PROTO_ICMP, 16'd20, 32'h0, 8'h00,
               8'h00, 34, FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h45, 8'h00, 16'd26, 32'h0, 8'h00, 8'h00, 40,
               FILL_RANDOM, 2'd0);
    make_frame(eipl_pkg::ETHERTYPE_IPV4, 8'h46, 8'hFF, 16'd26, 32'h0, 8'h00, 8'h00, 40,
               FILL_ONES, 2'd0);

    while (random_bytes < 1000 || random_frames < 20)
      make_random_frame(2'((random_frames / 5) % 4));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (wire_bytes.size() > 0 || in_chan.valid) @(posedge clk);
    while (frame_reports_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d frames, %0d bytes, %0d random frames over four idle phases",
             frames_checked, bytes_in, random_frames);
    $display("kinds seen: short %0d, non-ip %0d, tcp %0d, udp %0d, icmp %0d, other %0d",
             kind_seen[eipl_pkg::KIND_SHORT], kind_seen[eipl_pkg::KIND_NON_IP],
             kind_seen[eipl_pkg::KIND_TCP], kind_seen[eipl_pkg::KIND_UDP],
             kind_seen[eipl_pkg::KIND_ICMP], kind_seen[eipl_pkg::KIND_OTHER_IP]);
    $display("truncated transport %0d", kind_seen[eipl_pkg::KIND_TRUNCATED]);
    if (fail_count == 0 && frame_reports_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/eipl_pkg.sv
sv/eipl_if.sv
sv/eipl_capture.sv
sv/eipl_classify.sv
sv/eth_ipv4_l4_header_parser_unit.sv
sim/testbench.sv
